// ----- src/jst_pkg.sv -----
// Types and constants shared by the job slot table.
// No dependencies; the interfaces, jst_ctrl and the top level import this package.
package jst_pkg;

   localparam int CMD_W  = 3;
   localparam int PROC_W = 22;
   localparam int JOB_W  = 16;
   localparam int STAT_W = 3;
   localparam int RUN_W  = 2;

   localparam logic [JOB_W-1:0] JOB_MAX = {JOB_W{1'b1}};
   localparam logic [JOB_W-1:0] JOB_ONE = JOB_W'(1);

   // command codes (code 7 is unused)
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 3'd0,
      CMD_DELETE   = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_RESUME   = 3'd3,
      CMD_STOP_FG  = 3'd4,
      CMD_QUERY_FG = 3'd5,
      CMD_LOOKUP   = 3'd6
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_NOTFOUND = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_BADKEY   = 3'd3,
      STAT_WRAP     = 3'd4
   } stat_type;

   typedef enum logic [RUN_W-1:0] {
      RUN_UNDEF = 2'd0,
      RUN_FG    = 2'd1,
      RUN_BG    = 2'd2,
      RUN_STOP  = 2'd3
   } run_type;

   // what a scan compares each slot against
   typedef enum logic [1:0] {
      MATCH_PROC,
      MATCH_JOB,
      MATCH_FG
   } match_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_CHECK,
      S_DONE
   } ctrl_state_type;

   // one slot of the table as held in the slot RAM
   typedef struct packed {
      logic [PROC_W-1:0] proc;
      logic [JOB_W-1:0]  job;
      run_type           run;
   } entry_type;

   // one finished result handed from the sequencer to the output register
   typedef struct packed {
      stat_type          status;
      logic [PROC_W-1:0] proc;
      logic [JOB_W-1:0]  job;
      run_type           run;
   } result_type;

endpackage

// ----- src/jst_req_if.sv -----
// Command channel of the job slot table: valid/ready plus the command fields.
// Depends on jst_pkg for the field widths.
interface jst_req_if import jst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [PROC_W-1:0] proc_id;
   logic [JOB_W-1:0]  job_key;
   logic              key_is_job;
   logic              to_background;

   modport source (output valid, command, proc_id, job_key, key_is_job, to_background,
                   input ready);
   modport sink   (input valid, command, proc_id, job_key, key_is_job, to_background,
                   output ready);
endinterface

// ----- src/jst_rsp_if.sv -----
// Result channel of the job slot table: valid/ready plus the result fields.
// Depends on jst_pkg for the field widths.
interface jst_rsp_if import jst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [PROC_W-1:0] found_proc;
   logic [JOB_W-1:0]  found_job;
   logic [RUN_W-1:0]  found_state;

   modport source (output valid, status, found_proc, found_job, found_state,
                   input ready);
   modport sink   (input valid, status, found_proc, found_job, found_state,
                   output ready);
endinterface

// ----- src/jst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- src/jst_ctrl.sv -----
// Command sequencer of the job slot table: scans the slot RAM one entry a
// cycle, then writes back or frees the modified slot. Depends on jst_pkg, jst_req_if.
module jst_ctrl import jst_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   jst_req_if.sink                  req,
   // slot RAM
   output logic                     ram_we,
   output logic [$clog2(SLOTS)-1:0] ram_waddr,
   output entry_type                ram_wdata,
   output logic [$clog2(SLOTS)-1:0] ram_raddr,
   input  entry_type                ram_rdata,
   // finished result toward the output register
   output logic                     res_valid,
   output result_type               res,
   input  logic                     res_free
);

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
   localparam logic [JOB_W-1:0] SLOTS_J = JOB_W'(SLOTS);

   ctrl_state_type    state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [PROC_W-1:0] pid_ff, pid_in;
   logic [PROC_W-1:0] key_proc_ff, key_proc_in;
   logic [JOB_W-1:0]  key_job_ff, key_job_in;
   run_type           run_ff, run_in;
   match_type         mode_ff, mode_in;
   logic              early_ff, early_in;
   stat_type          early_stat_ff, early_stat_in;
   logic              pass2_ff, pass2_in;
   logic [JOB_W-1:0]  next_id_ff, next_id_in;
   logic [IW-1:0]     scan_addr_ff, scan_addr_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic              hit_ff, hit_in;
   logic [IW-1:0]     hit_idx_ff, hit_idx_in;
   entry_type         hit_entry_ff, hit_entry_in;
   logic [JOB_W-1:0]  maxj_ff, maxj_in;
   logic              valid_ff [SLOTS];

   entry_type         cur;
   logic              cur_match;
   logic              accept;
   logic              finish;
   logic              do_write;
   logic              do_clear;
   entry_type         new_entry;
   logic [JOB_W-1:0]  add_next;
   logic              key_zero;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign finish    = res_valid && res_free;

   // slot under evaluation; a slot never written since reset reads as free
   always_comb begin
      cur = valid_ff[rd_idx_ff] ? ram_rdata : '0;
      case (mode_ff)
         MATCH_PROC: cur_match = (cur.proc == key_proc_ff);
         MATCH_JOB:  cur_match = (cur.job == key_job_ff);
         MATCH_FG:   cur_match = (cur.run == RUN_FG);
         default:    cur_match = 1'b0;
      endcase
   end

   // next job id after an add
   always_comb begin
      add_next = next_id_ff + JOB_ONE;
      if (add_next == '0 || add_next > SLOTS_J) begin
         add_next = JOB_ONE;
      end
   end

   // selected key of zero for the keyed commands
   always_comb begin
      if (req.command inside {CMD_STOP, CMD_RESUME, CMD_LOOKUP}) begin
         key_zero = req.key_is_job ? (req.job_key == '0) : (req.proc_id == '0);
      end else begin
         key_zero = (req.proc_id == '0);
      end
   end

   // result and write-back for the finished command
   always_comb begin
      res       = '0;
      do_write  = 1'b0;
      do_clear  = 1'b0;
      new_entry = hit_entry_ff;
      if (early_ff) begin
         res.status = early_stat_ff;
      end else begin
         case (cmd_ff)
            CMD_ADD: begin
               new_entry.proc = pid_ff;
               new_entry.job  = next_id_ff;
               new_entry.run  = run_ff;
               do_write       = hit_ff;
            end
            CMD_STOP, CMD_STOP_FG: begin
               new_entry.run = RUN_STOP;
               do_write      = hit_ff;
            end
            CMD_RESUME: begin
               new_entry.run = run_ff;
               do_write      = hit_ff;
            end
            CMD_DELETE: begin
               do_clear = hit_ff;
            end
            default: begin
            end
         endcase
         if (!hit_ff) begin
            res.status = (cmd_ff == CMD_ADD) ? STAT_FULL : STAT_NOTFOUND;
         end else if (cmd_ff == CMD_QUERY_FG && hit_entry_ff.proc == '0) begin
            res.status = STAT_NOTFOUND;
         end else begin
            res.status = (cmd_ff == CMD_DELETE && maxj_ff == JOB_MAX) ? STAT_WRAP : STAT_OK;
            res.proc   = new_entry.proc;
            res.job    = new_entry.job;
            res.run    = new_entry.run;
         end
      end
   end

   // slot RAM ports
   assign ram_raddr = scan_addr_ff;
   assign ram_waddr = hit_idx_ff;
   assign ram_wdata = new_entry;
   assign ram_we    = finish && do_write;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pid_in        = pid_ff;
      key_proc_in   = key_proc_ff;
      key_job_in    = key_job_ff;
      run_in        = run_ff;
      mode_in       = mode_ff;
      early_in      = early_ff;
      early_stat_in = early_stat_ff;
      pass2_in      = pass2_ff;
      next_id_in    = next_id_ff;
      scan_addr_in  = scan_addr_ff;
      rd_pend_in    = (state_ff == S_SCAN);
      rd_idx_in     = scan_addr_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      maxj_in       = maxj_ff;

      // fold the slot read last cycle into the scan
      if (rd_pend_ff) begin
         if (cur_match && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_entry_in = cur;
         end else if (cur.job > maxj_ff) begin
            maxj_in = cur.job;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req.command;
               pid_in        = req.proc_id;
               key_proc_in   = (req.command == CMD_ADD) ? '0 : req.proc_id;
               key_job_in    = req.job_key;
               run_in        = req.to_background ? RUN_BG : RUN_FG;
               pass2_in      = 1'b0;
               scan_addr_in  = '0;
               hit_in        = 1'b0;
               maxj_in       = '0;
               early_in      = 1'b0;
               early_stat_in = STAT_BADKEY;
               if (req.command inside {CMD_STOP_FG, CMD_QUERY_FG}) begin
                  mode_in = MATCH_FG;
               end else if (req.command inside {CMD_STOP, CMD_RESUME, CMD_LOOKUP}
                            && req.key_is_job) begin
                  mode_in = MATCH_JOB;
               end else begin
                  mode_in = MATCH_PROC;
               end
               if (req.command inside {[CMD_ADD:CMD_RESUME], CMD_LOOKUP} && key_zero) begin
                  early_in = 1'b1;
                  state_in = S_DONE;
               end else if (req.command inside {[CMD_ADD:CMD_LOOKUP]}) begin
                  state_in = S_SCAN;
               end else begin
                  early_in      = 1'b1;
                  early_stat_in = STAT_NOTFOUND;
                  state_in      = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (scan_addr_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + IW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // stop foreground: rescan for the first slot with the found process id
            if (cmd_ff == CMD_STOP_FG && !pass2_ff && hit_ff) begin
               pass2_in     = 1'b1;
               key_proc_in  = hit_entry_ff.proc;
               mode_in      = MATCH_PROC;
               hit_in       = 1'b0;
               scan_addr_in = '0;
               state_in     = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (finish) begin
               state_in = S_IDLE;
               if (!early_ff && hit_ff && cmd_ff == CMD_ADD) begin
                  next_id_in = add_next;
               end else if (do_clear) begin
                  next_id_in = (maxj_ff == JOB_MAX) ? JOB_ONE : maxj_ff + JOB_ONE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         next_id_ff <= JOB_ONE;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         next_id_ff <= next_id_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   // per-slot written flags, cleared at reset and by delete
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (finish && (do_write || do_clear)) begin
         valid_ff[hit_idx_ff] <= do_write;
      end
   end

   // command and scan payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pid_ff        <= pid_in;
      key_proc_ff   <= key_proc_in;
      key_job_ff    <= key_job_in;
      run_ff        <= run_in;
      mode_ff       <= mode_in;
      early_ff      <= early_in;
      early_stat_ff <= early_stat_in;
      pass2_ff      <= pass2_in;
      scan_addr_ff  <= scan_addr_in;
      rd_idx_ff     <= rd_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_entry_ff  <= hit_entry_in;
      maxj_ff       <= maxj_in;
   end

endmodule

// ----- src/job_slot_table_top.sv -----
// Job slot table top level: sequencer, slot RAM and result register.
// Depends on jst_pkg, jst_req_if, jst_rsp_if, jst_ram and jst_ctrl.

// A table of SLOTS job slots (process id, job id, run state), all free after
// reset. Commands are taken one at a time: add, delete, mark stopped, resume,
// lookup and query foreground make one scan of the slot RAM, stop foreground
// makes two when a foreground job exists (a second scan finds the first slot
// with its process id) and one when none does, and a rejected key or an
// unused command makes none. A scan reads one slot per cycle through the
// single read port of the slot RAM; a whole scan is always made so that
// delete can find the largest remaining job id. The result sits in an output
// register, so a new command is taken while the last result waits for its
// transfer; a command that finishes while the register is still full waits
// until it drains. No clearing pass follows reset.
module job_slot_table_top import jst_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic     clock,
   input  logic     reset,
   jst_req_if.sink  req,
   jst_rsp_if.source rsp
);

   localparam int IW = $clog2(SLOTS);

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [IW-1:0] ram_raddr;
   entry_type     ram_wdata;
   entry_type     ram_rdata;
   logic          res_valid;
   result_type    res;
   logic          res_free;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff, rsp_data_in;

   jst_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .res_valid (res_valid),
      .res       (res),
      .res_free  (res_free)
   );

   jst_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // result register: loads when empty or being drained this cycle
   assign res_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_data_ff.status;
   assign rsp.found_proc  = rsp_data_ff.proc;
   assign rsp.found_job   = rsp_data_ff.job;
   assign rsp.found_state = rsp_data_ff.run;

endmodule
